### src/ksbl_pkg.sv
// shared types and constants of the k-th successor binary lifting core
// no dependencies
`timescale 1ns / 1ps

package ksbl_pkg;

	// default table geometry
	localparam int NODES_DEF  = 1024;
	localparam int LEVELS_DEF = 31;

	// fixed field widths
	localparam int OP_W    = 2;
	localparam int NODE_FW = 10;
	localparam int STEPS_W = 31;
	localparam int COUNT_W = 11;

	// reset value of the node count register
	localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

	// item operation codes
	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

endpackage

### src/ksbl_if.sv
// valid/ready channel interfaces for items and results
// depends on ksbl_pkg
`timescale 1ns / 1ps

interface ksbl_cmd_if import ksbl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [NODE_FW-1:0] node;
	logic [NODE_FW-1:0] successor;
	logic [STEPS_W-1:0] steps;

	modport source (output valid, output op, output node, output successor, output steps,
		input ready);
	modport sink (input valid, input op, input node, input successor, input steps,
		output ready);
endinterface

interface ksbl_res_if import ksbl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [NODE_FW-1:0] destination;

	modport source (output valid, output destination, input ready);
	modport sink (input valid, input destination, output ready);
endinterface

### src/ksbl_table_mem.sv
// jump table memory: one write port, one read port, registered read data
// depends on ksbl_pkg
`timescale 1ns / 1ps

module ksbl_table_mem import ksbl_pkg::*; #(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF,
	localparam int NODE_W = $clog2(NODES),
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1,
	localparam int ADDR_W = LVL_W + NODE_W
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [NODE_FW-1:0] rd_data,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [NODE_FW-1:0] wr_data
);

	localparam int DEPTH = LEVELS * (2 ** NODE_W);

	logic [NODE_FW-1:0] mem [DEPTH];
	logic [NODE_FW-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/ksbl_ctrl.sv
// sequencer for load, table build and query walk over the jump table memory
// depends on ksbl_pkg and ksbl_if
`timescale 1ns / 1ps

module ksbl_ctrl import ksbl_pkg::*; #(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF,
	localparam int NODE_W = $clog2(NODES),
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1,
	localparam int ADDR_W = LVL_W + NODE_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [COUNT_W-1:0] cfg_write_data,
	ksbl_cmd_if.sink           cmd,
	ksbl_res_if.source         res,
	output logic               rd_en,
	output logic [ADDR_W-1:0]  rd_addr,
	input  logic [NODE_FW-1:0] rd_data,
	output logic               wr_en,
	output logic [ADDR_W-1:0]  wr_addr,
	output logic [NODE_FW-1:0] wr_data
);

	// compare width covers node count register and node range
	localparam int CMP_W = ($clog2(NODES + 1) > COUNT_W) ? $clog2(NODES + 1) : COUNT_W;
	localparam logic [CMP_W-1:0] NODES_C    = CMP_W'(NODES);
	localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(LEVELS - 1);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_BLD_RD1 = 7'b0000010,
		S_BLD_RD2 = 7'b0000100,
		S_BLD_WR  = 7'b0001000,
		S_QRY     = 7'b0010000,
		S_QRY_RD  = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] node_count_q;
	logic [CMP_W-1:0]   count_q;
	logic [CMP_W-1:0]   j_q;
	logic [LVL_W-1:0]   lvl_q;
	logic [NODE_FW-1:0] cur_q;
	logic [STEPS_W-1:0] steps_q;
	logic               half_ok_q;
	logic               res_valid_q;
	logic [NODE_FW-1:0] res_dest_q;

	logic               cmd_xfer;
	logic [CMP_W-1:0]   count_sat;
	logic               node_ok;
	logic               cur_ok;
	logic               half_ok;
	logic [CMP_W-1:0]   j_next;
	logic [STEPS_W-1:0] steps_next;
	logic               qry_last;
	op_t                op;

	assign op        = op_t'(cmd.op);
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;

	// node count saturated to the table size
	assign count_sat = (CMP_W'(node_count_q) > NODES_C) ? NODES_C : CMP_W'(node_count_q);

	// range checks: indexes at or above the table size read as node zero; an out-of-range load is dropped
	assign node_ok = CMP_W'(cmd.node) < NODES_C;
	assign cur_ok  = CMP_W'(cur_q) < NODES_C;
	assign half_ok = CMP_W'(rd_data) < NODES_C;

	assign j_next     = j_q + 1'b1;
	assign steps_next = steps_q >> 1;
	assign qry_last   = (lvl_q == LAST_LEVEL) || (steps_next == '0);

	// memory read requests
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {lvl_q, NODE_W'(cur_q)};
		case (state_q)
			S_BLD_RD1: begin
				rd_en   = 1'b1;
				rd_addr = {LVL_W'(lvl_q - 1'b1), j_q[NODE_W-1:0]};
			end
			S_BLD_RD2: begin
				rd_en   = half_ok;
				rd_addr = {LVL_W'(lvl_q - 1'b1), NODE_W'(rd_data)};
			end
			S_QRY: begin
				rd_en   = steps_q[0] && cur_ok;
				rd_addr = {lvl_q, NODE_W'(cur_q)};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// memory write requests
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {LVL_W'(0), NODE_W'(cmd.node)};
		wr_data = cmd.successor;
		case (state_q)
			S_IDLE: begin
				wr_en = cmd_xfer && (op == OP_LOAD) && node_ok;
			end
			S_BLD_WR: begin
				wr_en   = 1'b1;
				wr_addr = {lvl_q, j_q[NODE_W-1:0]};
				wr_data = half_ok_q ? rd_data : '0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= COUNT_RST;
		end else if (cfg_write_en) begin
			node_count_q <= cfg_write_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			j_q     <= '0;
			lvl_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_xfer) begin
						case (op)
							OP_BUILD: begin
								count_q <= count_sat;
								j_q     <= '0;
								lvl_q   <= LVL_W'(1);
								if (LEVELS > 1 && count_sat != '0) begin
									state_q <= S_BLD_RD1;
								end
							end
							OP_QUERY: begin
								lvl_q   <= '0;
								state_q <= S_QRY;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_BLD_RD1: begin
					state_q <= S_BLD_RD2;
				end
				S_BLD_RD2: begin
					state_q <= S_BLD_WR;
				end
				S_BLD_WR: begin
					if (j_next == count_q) begin
						j_q <= '0;
						if (lvl_q == LAST_LEVEL) begin
							state_q <= S_IDLE;
						end else begin
							lvl_q   <= lvl_q + 1'b1;
							state_q <= S_BLD_RD1;
						end
					end else begin
						j_q     <= j_next;
						state_q <= S_BLD_RD1;
					end
				end
				S_QRY: begin
					if (steps_q[0] && cur_ok) begin
						state_q <= S_QRY_RD;
					end else if (qry_last) begin
						state_q <= S_DONE;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				S_QRY_RD: begin
					if (qry_last) begin
						state_q <= S_DONE;
					end else begin
						lvl_q   <= lvl_q + 1'b1;
						state_q <= S_QRY;
					end
				end
				S_DONE: begin
					if (!res_valid_q || res.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// query walk datapath and build range flag
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cur_q   <= cmd.node;
			steps_q <= cmd.steps;
		end
		if (state_q == S_BLD_RD2) begin
			half_ok_q <= half_ok;
		end
		if (state_q == S_QRY) begin
			if (steps_q[0] && !cur_ok) begin
				cur_q <= '0;
			end
			if (!(steps_q[0] && cur_ok)) begin
				steps_q <= steps_next;
			end
		end
		if (state_q == S_QRY_RD) begin
			cur_q   <= rd_data;
			steps_q <= steps_next;
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!res_valid_q || res.ready)) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!res_valid_q || res.ready)) begin
			res_dest_q <= cur_q;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.destination = res_dest_q;

endmodule

### src/kth_successor_binary_lifting_core.sv
// Sequence: a load is written as it is taken; a build does a read, read, write per entry over
// levels 1..LEVELS-1 and the first min(node_count, NODES) nodes; a query visits one level per step
// bit up to its highest set bit (at least one) with a table read per set bit, then fills the output register.
// Items are taken one at a time; a waiting result blocks only a query that finishes behind it.
// Reset clears the sequencer and output valid and sets node_count to 1024; the jump table is not
// cleared and holds unknown data until loaded and built.
// top level: jump table memory plus sequencer; depends on ksbl_pkg, ksbl_if
`timescale 1ns / 1ps

module kth_successor_binary_lifting_core import ksbl_pkg::*; #(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [COUNT_W-1:0] cfg_write_data,
	ksbl_cmd_if.sink           cmd,
	ksbl_res_if.source         res
);

	localparam int NODE_W = $clog2(NODES);
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ADDR_W = LVL_W + NODE_W;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [NODE_FW-1:0] rd_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [NODE_FW-1:0] wr_data;

	// sequencer
	ksbl_ctrl #(
		.NODES  (NODES),
		.LEVELS (LEVELS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.cmd            (cmd),
		.res            (res),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data)
	);

	// jump table
	ksbl_table_mem #(
		.NODES  (NODES),
		.LEVELS (LEVELS)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

### tb/ksbl_scoreboard.sv
// scoreboard for the k-th successor core: watches item, result and register traffic,
// predicts each destination and compares it in order
// depends on ksbl_pkg and ksbl_if
`timescale 1ns / 1ps

module ksbl_scoreboard import ksbl_pkg::*; #(
	parameter int NODES  = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [COUNT_W-1:0] cfg_write_data,
	ksbl_cmd_if                cmd,
	ksbl_res_if                res,
	output int                 mismatches,
	output int                 pending,
	output int                 queries_checked,
	output int                 loads_seen,
	output int                 builds_seen
);

	// predicted jump table, level-major, and the node count it is built over
	logic [NODE_FW-1:0] hop_table [LEVELS][NODES];
	logic [COUNT_W-1:0] count_reg;
	logic [NODE_FW-1:0] dest_expected [$];
	logic [NODE_FW-1:0] want;

	initial begin
		for (int lvl = 0; lvl < LEVELS; lvl++) begin
			for (int j = 0; j < NODES; j++) begin
				hop_table[lvl][j] = '0;
			end
		end
	end

	// every level is the level below applied twice, over the covered nodes only
	function automatic void rebuild_levels();
		int span;
		span = (count_reg > NODES) ? NODES : int'(count_reg);
		for (int lvl = 1; lvl < LEVELS; lvl++) begin
			for (int j = 0; j < span; j++) begin
				hop_table[lvl][j] = hop_table[lvl-1][hop_table[lvl-1][j]];
			end
		end
	endfunction

	// one jump per set bit of the step count, lowest bit first
	function automatic logic [NODE_FW-1:0] walk_steps(input logic [NODE_FW-1:0] start,
		input logic [STEPS_W-1:0] hops);
		logic [NODE_FW-1:0] cur;
		cur = start;
		for (int lvl = 0; lvl < LEVELS && lvl < STEPS_W; lvl++) begin
			if (hops[lvl]) begin
				cur = (cur < NODES) ? hop_table[lvl][cur] : '0;
			end
		end
		return cur;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] destination check: %s", $time, what);
		mismatches <= mismatches + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_reg = COUNT_RST;
			dest_expected.delete();
			mismatches <= 0;
			pending <= 0;
			queries_checked <= 0;
			loads_seen <= 0;
			builds_seen <= 0;
		end else begin
			// register write, only ever done while the core is idle
			if (cfg_write_en) begin
				count_reg = cfg_write_data;
			end

			// result transfer against the oldest prediction
			if (res.valid && res.ready) begin
				if (dest_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected destination %0d", res.destination));
				end else begin
					want = dest_expected.pop_front();
					if (res.destination !== want) begin
						report_mismatch($sformatf("destination %0d, predicted %0d",
							res.destination, want));
					end
					queries_checked <= queries_checked + 1;
				end
			end

			// item transfer updates the table or queues a prediction
			if (cmd.valid && cmd.ready) begin
				case (op_t'(cmd.op))
					OP_LOAD: begin
						if (cmd.node < NODES) begin
							hop_table[0][cmd.node] = cmd.successor;
						end
						loads_seen <= loads_seen + 1;
					end
					OP_BUILD: begin
						rebuild_levels();
						builds_seen <= builds_seen + 1;
					end
					OP_QUERY: begin
						dest_expected.push_back(walk_steps(cmd.node, cmd.steps));
					end
					default: begin
					end
				endcase
			end

			pending <= dest_expected.size();
		end
	end

endmodule

### tb/tb_kth_successor_binary_lifting_core.sv
// top of the k-th successor core testbench: clock, reset, item and register stimulus,
// result backpressure and the verdict
// depends on ksbl_pkg, ksbl_if, the core and ksbl_scoreboard
`timescale 1ns / 1ps

module tb_kth_successor_binary_lifting_core;
	import ksbl_pkg::*;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_PCT     = 9;
	localparam int DIRECT_SPAN  = 64;

	logic               clk;
	logic               arst_n;
	logic               cfg_write_en;
	logic [COUNT_W-1:0] cfg_write_data;
	logic               steady;
	int                 cycle_count;
	op_t                last_op;
	int                 span_now;
	int                 random_items;
	int                 settings_written;
	int                 phase_idx;

	int mismatches;
	int pending;
	int queries_checked;
	int loads_seen;
	int builds_seen;

	ksbl_cmd_if cmd();
	ksbl_res_if res();

	kth_successor_binary_lifting_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.cmd            (cmd),
		.res            (res)
	);

	ksbl_scoreboard scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.cmd             (cmd),
		.res             (res),
		.mismatches      (mismatches),
		.pending         (pending),
		.queries_checked (queries_checked),
		.loads_seen      (loads_seen),
		.builds_seen     (builds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls at random outside the steady stretch
	always @(posedge clk) begin
		res.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles with %0d destinations outstanding",
				cycle_count, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one item transfer, with an occasional idle gap in front of it
	task automatic send_item(input op_t op, input logic [NODE_FW-1:0] nd,
		input logic [NODE_FW-1:0] sc, input logic [STEPS_W-1:0] st);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.op        <= op;
		cmd.node      <= nd;
		cmd.successor <= sc;
		cmd.steps     <= st;
		do @(posedge clk); while (!cmd.ready);
		last_op = op;
	endtask

	// drain results, then cover a build that may still be running
	task automatic settle();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat ((last_op == OP_BUILD) ? 3 * (LEVELS_DEF - 1) * span_now + 16 : 16) @(posedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] val);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		span_now = (val > NODES_DEF) ? NODES_DEF : int'(val);
		settings_written++;
	endtask

	// successors of nodes 0..n-1, all inside the same range
	task automatic fill_graph(input int n);
		for (int j = 0; j < n; j++) begin
			send_item(OP_LOAD, NODE_FW'(j), NODE_FW'($urandom_range(0, n - 1)),
				STEPS_W'($urandom()));
		end
	endtask

	function automatic logic [STEPS_W-1:0] pick_steps();
		logic [STEPS_W-1:0] val;
		case ($urandom_range(0, 4))
			0: val = STEPS_W'($urandom_range(0, 63));
			1: val = STEPS_W'(1) << $urandom_range(0, STEPS_W - 1);
			2: val = {STEPS_W{1'b1}} >> $urandom_range(0, STEPS_W - 1);
			default: val = STEPS_W'($urandom());
		endcase
		return val;
	endfunction

	// one node-count setting: fresh graph, build, then a mix of traffic
	task automatic run_phase(input int count_val, input int body_items);
		int pick;
		settle();
		write_count(COUNT_W'(count_val));
		fill_graph(span_now);
		random_items += span_now;
		send_item(OP_BUILD, NODE_FW'($urandom()), NODE_FW'($urandom()), STEPS_W'($urandom()));
		random_items++;
		for (int i = 0; i < body_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick >= 86 && pick < 92) begin
				// unused op code, must leave everything untouched
				send_item(OP_NONE, NODE_FW'($urandom()), NODE_FW'($urandom()),
					STEPS_W'($urandom()));
			end else begin
				random_items++;
				if (pick < 55) begin
					send_item(OP_QUERY, NODE_FW'($urandom_range(0, span_now - 1)),
						NODE_FW'($urandom()), pick_steps());
				end else if (pick < 70) begin
					// reload without rebuild leaves the upper levels stale but valid
					send_item(OP_LOAD, NODE_FW'($urandom_range(0, span_now - 1)),
						NODE_FW'($urandom_range(0, span_now - 1)), STEPS_W'($urandom()));
				end else if (pick < 78) begin
					send_item(OP_BUILD, NODE_FW'($urandom()), NODE_FW'($urandom()),
						STEPS_W'($urandom()));
				end else if (pick < 86 && span_now < NODES_DEF) begin
					// node outside the covered range, never reached by a query
					send_item(OP_LOAD, NODE_FW'($urandom_range(span_now, NODES_DEF - 1)),
						NODE_FW'($urandom()), STEPS_W'($urandom()));
				end else begin
					send_item(OP_QUERY, NODE_FW'($urandom_range(0, span_now - 1)),
						NODE_FW'($urandom()),
						($urandom_range(0, 1) != 0) ? {STEPS_W{1'b1}} : '0);
				end
			end
		end
		send_item(OP_QUERY, NODE_FW'($urandom_range(0, span_now - 1)), NODE_FW'($urandom()),
			pick_steps());
		random_items++;
	endtask

	initial begin
		int cnt;
		cmd.valid        <= 1'b0;
		cmd.op           <= OP_NONE;
		cmd.node         <= '0;
		cmd.successor    <= '0;
		cmd.steps        <= '0;
		cfg_write_en     <= 1'b0;
		cfg_write_data   <= COUNT_RST;
		arst_n           <= 1'b0;
		steady           = 1'b0;
		last_op          = OP_NONE;
		span_now         = NODES_DEF;
		random_items     = 0;
		settings_written = 0;
		phase_idx        = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reduced graph with boundary queries at both ends of the covered range
		write_count(COUNT_W'(DIRECT_SPAN));
		fill_graph(span_now);
		send_item(OP_LOAD, '0, NODE_FW'(DIRECT_SPAN - 1), '0);
		send_item(OP_LOAD, NODE_FW'(DIRECT_SPAN - 1), '0, {STEPS_W{1'b1}});
		send_item(OP_BUILD, '0, '0, '0);
		send_item(OP_QUERY, '0, '0, '0);
		send_item(OP_QUERY, NODE_FW'(DIRECT_SPAN - 1), '1, '0);
		send_item(OP_QUERY, '0, '0, STEPS_W'(1));
		send_item(OP_QUERY, NODE_FW'(DIRECT_SPAN - 1), '0, {STEPS_W{1'b1}});
		send_item(OP_QUERY, NODE_FW'(DIRECT_SPAN / 2), '0, STEPS_W'(1) << (STEPS_W - 1));
		send_item(OP_NONE, '1, '1, {STEPS_W{1'b1}});
		send_item(OP_QUERY, NODE_FW'(DIRECT_SPAN - 1), '0, 31'h5555_5555);
		for (int i = 0; i < 30; i++) begin
			send_item(OP_QUERY, NODE_FW'($urandom_range(0, DIRECT_SPAN - 1)),
				NODE_FW'($urandom()), pick_steps());
		end

		// zero count, build must change nothing
		settle();
		write_count('0);
		send_item(OP_BUILD, '0, '0, '0);
		send_item(OP_QUERY, '0, '0, {STEPS_W{1'b1}});
		send_item(OP_QUERY, NODE_FW'(DIRECT_SPAN - 1), '0, STEPS_W'(3));

		// single node looping on itself
		settle();
		write_count(COUNT_W'(1));
		send_item(OP_LOAD, '0, '0, '0);
		send_item(OP_BUILD, '0, '0, '0);
		send_item(OP_QUERY, '0, '1, {STEPS_W{1'b1}});
		send_item(OP_QUERY, '0, '0, '0);

		// random phases, two of them with no idling on either side
		while (random_items < RANDOM_ITEMS) begin
			steady = (phase_idx == 2 || phase_idx == 3);
			case ($urandom_range(0, 9))
				0: cnt = 1;
				1: cnt = $urandom_range(100, 200);
				default: cnt = $urandom_range(2, 40);
			endcase
			run_phase(cnt, $urandom_range(20, 50));
			phase_idx++;
		end
		steady = 1'b0;

		settle();
		repeat (200) @(posedge clk);

		$display("covered %0d loads, %0d builds and %0d checked queries over %0d count writes",
			loads_seen, builds_seen, queries_checked, settings_written);
		$display("random part: %0d phases, %0d items, %0d cycles", phase_idx, random_items,
			cycle_count);
		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d destinations never arrived", mismatches, pending);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
